[src/coalescing_dispatch_scheduler_core_defines.svh]
// ----------------------------------------------------------------------------
// Coalescing dispatch scheduler assertion macros
// Shared assertion helpers, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef COALESCING_DISPATCH_SCHEDULER_CORE_DEFINES_SVH
`define COALESCING_DISPATCH_SCHEDULER_CORE_DEFINES_SVH

// Expression must hold in the same cycle.
`define CDS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define CDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/cds_pkg.sv]
// ----------------------------------------------------------------------------
// Coalescing dispatch scheduler package
// Item types, command classes, event codes and reset constants.
// ----------------------------------------------------------------------------
package cds_pkg;

  localparam logic [6:0] NonePri       = 7'd100;
  localparam logic [6:0] MaxServedRst  = 7'd4;
  localparam logic [6:0] GatedPriRst   = 7'd30;
  localparam logic [7:0] SettleGateRst = 8'd2;

  typedef enum logic [1:0] {
    FUNC_CANCEL = 2'd0,
    FUNC_ACTION = 2'd1,
    FUNC_TICK   = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    EV_ACCEPTED      = 3'd0,
    EV_SKIPPED       = 3'd1,
    EV_RUN_CANCEL    = 3'd2,
    EV_RUN_ACTION    = 3'd3,
    EV_GATE_DEFERRED = 3'd4,
    EV_TICK_END      = 3'd5
  } event_e;

  typedef enum logic [1:0] {
    CFG_MAX_SERVED  = 2'd0,
    CFG_GATED_PRI   = 2'd1,
    CFG_SETTLE_GATE = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CMD_CANCEL,
    CMD_ACTION,
    CMD_TICK,
    CMD_REJECT
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIMPLE,
    ST_ENQ,
    ST_SCAN,
    ST_END
  } state_e;

  typedef struct packed {
    logic [1:0] func;
    logic [3:0] slot;
    logic [6:0] priority_req;
    logic [7:0] tag;
    logic [7:0] settling_count;
  } in_t;

  typedef struct packed {
    event_e     event_res;
    logic [3:0] slot_res;
    logic [6:0] priority_res;
    logic [7:0] tag_res;
    logic       last;
  } out_t;

  typedef struct packed {
    cmd_e       kind;
    logic [3:0] slot;
    logic [6:0] pri;
    logic [7:0] tag;
    logic [7:0] settling;
  } cmd_t;

  typedef struct packed {
    logic [6:0] max_served;
    logic [6:0] gated_pri;
    logic [7:0] settle_gate;
  } cfg_t;

  typedef struct packed {
    logic [6:0] pri;
    logic [7:0] tag;
  } act_t;

endpackage

[src/coalescing_dispatch_scheduler_core.sv]
// ----------------------------------------------------------------------------
// Coalescing dispatch scheduler core
// Per-slot cancel and action coalescing with budgeted, gated dispatch ticks.
// ----------------------------------------------------------------------------
// Usage: input items arrive on in_i with in_valid_i and are taken when
// in_stall_o is low. Each item gives one result item on out_o with
// out_valid_o, or SLOTS + 1 results for a dispatch tick; the last result of
// every input item carries last = 1. The receiver holds results back with
// out_stall_i; the result register then keeps its item and the scheduler
// waits, while the two-entry command queue goes on taking input items.
// An enqueue, cancel or rejected item passes the idle and a result state; a
// tick the idle, scan and end states, its scan reading one slot entry per
// cycle while the output is not stalled, from the single read port of the
// action store. Configuration is written through cfg_we_i, cfg_index_i and
// cfg_wdata_i; the user must write it only while the block is idle; the
// block does not enforce this. Reset empties every slot and restores the
// register defaults at once; no clearing pass is needed, because a slot's
// stored priority and tag are only consulted while its pending bit is set.
// ----------------------------------------------------------------------------
module coalescing_dispatch_scheduler_core #(
  parameter int SLOTS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cds_pkg::in_t  in_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output cds_pkg::out_t out_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_index_i,
  input  logic [7:0]    cfg_wdata_i
);
  import cds_pkg::*;

  cfg_t cfg_q, cfg_d;
  cmd_t head;
  logic head_valid;
  logic pop;

  // Configuration registers. Writes to an index beyond the list are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MAX_SERVED:  cfg_d.max_served  = cfg_wdata_i[6:0];
        CFG_GATED_PRI:   cfg_d.gated_pri   = cfg_wdata_i[6:0];
        CFG_SETTLE_GATE: cfg_d.settle_gate = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{max_served: MaxServedRst, gated_pri: GatedPriRst,
                 settle_gate: SettleGateRst};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // The front end classifies each item and queues it; the back end works
  // through the queue one command at a time.
  cds_front #(
    .SLOTS (SLOTS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .head_o       (head),
    .head_valid_o (head_valid),
    .pop_i        (pop)
  );

  cds_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .out_o        (out_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i)
  );

endmodule

[src/cds_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cds_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/cds_front.sv]
// ----------------------------------------------------------------------------
// Scheduler front end
// Accepts input items, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module cds_front #(
  parameter int SLOTS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cds_pkg::in_t  in_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output cds_pkg::cmd_t head_o,
  output logic          head_valid_o,
  input  logic          pop_i
);
  import cds_pkg::*;

  localparam logic [6:0] SlotsLim = 7'(SLOTS);

  cmd_t       fifo_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push;
  logic       in_range;
  cmd_t       cmd;

  // Cancels and enqueues to slots beyond the configured count, and the unused
  // function code, become rejections that the back end reports as skipped.
  assign in_range = ({3'b000, in_i.slot} < SlotsLim);

  always_comb begin
    cmd = '{kind: CMD_REJECT, slot: in_i.slot, pri: in_i.priority_req,
            tag: in_i.tag, settling: in_i.settling_count};
    case (in_i.func)
      FUNC_CANCEL: begin
        if (in_range) cmd.kind = CMD_CANCEL;
      end
      FUNC_ACTION: begin
        if (in_range) cmd.kind = CMD_ACTION;
      end
      FUNC_TICK: begin
        cmd.kind = CMD_TICK;
      end
      default: begin
        cmd.pri = NonePri;
        cmd.tag = '0;
      end
    endcase
  end

  assign in_stall_o   = (count_q == 2'd2);
  assign push         = in_valid_i && !in_stall_o;
  assign head_valid_o = (count_q != 2'd0);
  assign head_o       = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

[src/cds_back.sv]
// ----------------------------------------------------------------------------
// Scheduler back end
// Sequencer that executes queued commands and scans the slots on a tick.
// ----------------------------------------------------------------------------
`include "coalescing_dispatch_scheduler_core_defines.svh"

module cds_back #(
  parameter int SLOTS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cds_pkg::cfg_t cfg_i,
  input  cds_pkg::cmd_t head_i,
  input  logic          head_valid_i,
  output logic          pop_o,
  output cds_pkg::out_t out_o,
  output logic          out_valid_o,
  input  logic          out_stall_i
);
  import cds_pkg::*;

  localparam int SlotW = $clog2(SLOTS);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(SLOTS - 1);

  state_e           state_q, state_d;
  cmd_t             cmd_q;
  logic [SLOTS-1:0] cp_q, cp_d;
  logic [SLOTS-1:0] ran_q, ran_d;
  logic [SLOTS-1:0] ap_q, ap_d;
  logic [SlotW-1:0] scan_q, scan_d;
  logic [6:0]       served_q, served_d;
  out_t             out_q, res;
  logic             out_valid_q, out_valid_d;
  logic             emit, emit_ok;
  logic [SlotW-1:0] cmd_idx, head_idx, rd_addr;
  logic             ram_we;
  act_t             ram_wdata, rd;
  logic [6:0]       cur_pri;
  logic [7:0]       cur_tag;
  logic             take;

  assign emit_ok  = !out_valid_q || !out_stall_i;
  assign cmd_idx  = SlotW'(cmd_q.slot);
  assign head_idx = SlotW'(head_i.slot);

  // A slot without a pending action always reads as the empty priority.
  assign cur_pri = ap_q[scan_q] ? rd.pri : NonePri;
  assign cur_tag = ap_q[scan_q] ? rd.tag : 8'd0;
  assign take    = !ap_q[cmd_idx] || (cmd_q.pri < rd.pri) || (rd.tag == cmd_q.tag);

  cds_ram #(
    .Width ($bits(act_t)),
    .Depth (SLOTS)
  ) u_act_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cmd_idx),
    .wdata_i (ram_wdata),
    .raddr_i (rd_addr),
    .rdata_o (rd)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (head_valid_i) begin
          case (head_i.kind)
            CMD_ACTION: state_d = ST_ENQ;
            CMD_TICK:   state_d = ST_SCAN;
            default:    state_d = ST_SIMPLE;
          endcase
        end
      end
      ST_SIMPLE, ST_ENQ: begin
        if (emit_ok) state_d = ST_IDLE;
      end
      ST_SCAN: begin
        if (emit_ok && (scan_q == LastSlot)) state_d = ST_END;
      end
      ST_END: begin
        if (emit_ok) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o     = 1'b0;
    rd_addr   = '0;
    ram_we    = 1'b0;
    ram_wdata = '{pri: cmd_q.pri, tag: cmd_q.tag};
    emit      = 1'b0;
    res       = '{event_res: EV_SKIPPED, slot_res: cmd_q.slot, priority_res: NonePri,
                  tag_res: 8'd0, last: 1'b0};
    cp_d      = cp_q;
    ran_d     = ran_q;
    ap_d      = ap_q;
    scan_d    = scan_q;
    served_d  = served_q;
    case (state_q)
      ST_IDLE: begin
        pop_o    = head_valid_i;
        scan_d   = '0;
        served_d = '0;
        if (head_i.kind == CMD_ACTION) rd_addr = head_idx;
      end
      ST_SIMPLE: begin
        res.last = 1'b1;
        if (cmd_q.kind == CMD_CANCEL) begin
          res.event_res = EV_ACCEPTED;
        end else begin
          res.priority_res = cmd_q.pri;
          res.tag_res      = cmd_q.tag;
        end
        if (emit_ok) begin
          emit = 1'b1;
          if (cmd_q.kind == CMD_CANCEL) begin
            cp_d[cmd_idx]  = 1'b1;
            ran_d[cmd_idx] = 1'b0;
          end
        end
      end
      ST_ENQ: begin
        rd_addr          = cmd_idx;
        res.priority_res = cmd_q.pri;
        res.tag_res      = cmd_q.tag;
        res.last         = 1'b1;
        if (take) res.event_res = EV_ACCEPTED;
        if (emit_ok) begin
          emit = 1'b1;
          if (take) begin
            ram_we         = 1'b1;
            ap_d[cmd_idx]  = 1'b1;
            ran_d[cmd_idx] = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        rd_addr      = scan_q;
        res.slot_res = 4'(scan_q);
        if (served_q >= cfg_i.max_served) begin
          res.event_res = EV_SKIPPED;
        end else if (cp_q[scan_q] && !ran_q[scan_q]) begin
          res.event_res = EV_RUN_CANCEL;
        end else if (ran_q[scan_q]) begin
          res.priority_res = cur_pri;
          res.tag_res      = cur_tag;
        end else if (ap_q[scan_q]) begin
          res.priority_res = cur_pri;
          res.tag_res      = cur_tag;
          if ((cur_pri >= cfg_i.gated_pri) && (cmd_q.settling >= cfg_i.settle_gate)) begin
            res.event_res = EV_GATE_DEFERRED;
          end else begin
            res.event_res = EV_RUN_ACTION;
          end
        end
        if (emit_ok) begin
          emit = 1'b1;
          if (scan_q != LastSlot) begin
            scan_d  = scan_q + SlotW'(1);
            rd_addr = scan_q + SlotW'(1);
          end
          if (served_q < cfg_i.max_served) begin
            if (cp_q[scan_q] && !ran_q[scan_q]) begin
              cp_d[scan_q]  = 1'b0;
              ran_d[scan_q] = 1'b1;
              served_d      = served_q + 7'd1;
            end else if (ran_q[scan_q]) begin
              ran_d[scan_q] = 1'b0;
            end else if (res.event_res == EV_RUN_ACTION) begin
              ap_d[scan_q] = 1'b0;
              served_d     = served_q + 7'd1;
            end
          end
        end
      end
      ST_END: begin
        res.event_res = EV_TICK_END;
        res.slot_res  = 4'd0;
        res.last      = 1'b1;
        emit          = emit_ok;
      end
      default: ;
    endcase
  end

  assign out_valid_d = emit || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i) begin
    if (pop_o) cmd_q <= head_i;
    if (emit)  out_q <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cp_q        <= '0;
      ran_q       <= '0;
      ap_q        <= '0;
      scan_q      <= '0;
      served_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cp_q        <= cp_d;
      ran_q       <= ran_d;
      ap_q        <= ap_d;
      scan_q      <= scan_d;
      served_q    <= served_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_o       = out_q;
  assign out_valid_o = out_valid_q;

  `CDS_ASSERT_NOW(a_pop_needs_head, pop_o, head_valid_i, "pop from an empty queue")
  `CDS_ASSERT_NOW(a_budget_kept, state_q == ST_SCAN, served_q <= cfg_i.max_served,
                  "tick served more slots than the budget")
  `CDS_ASSERT_NOW(a_end_after_scan, state_q == ST_END, scan_q == LastSlot,
                  "tick end reached before the last slot")
  `CDS_ASSERT_NEXT(a_emit_shown, emit, out_valid_q, "emitted result not presented")

endmodule
